>>> sv/thumbstick_nav_autorepeat_mapper_top_assert.svh
// ----------------------------------------------------------------------------
// thumbstick mapper assertion macros
// shared concurrent assertion forms, sampled on clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef THUMBSTICK_NAV_AUTOREPEAT_MAPPER_TOP_ASSERT_SVH
`define THUMBSTICK_NAV_AUTOREPEAT_MAPPER_TOP_ASSERT_SVH

// same-cycle implication
`define TNAM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TNAM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/tnam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnam_pkg
// types, codes and helper functions of the thumbstick mapper
// ----------------------------------------------------------------------------
package tnam_pkg;

	// register indexes
	localparam logic [2:0] REG_UI_MODE        = 3'd0;
	localparam logic [2:0] REG_DEAD_ZONE      = 3'd1;
	localparam logic [2:0] REG_TRIG_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_REPEAT_DELAY   = 3'd3;
	localparam logic [2:0] REG_REPEAT_IVAL    = 3'd4;

	// reset values, 0.6 and 0.5 in unsigned Q0.15
	localparam logic [14:0] DEAD_ZONE_RST      = 15'd19661;
	localparam logic [14:0] TRIG_THRESHOLD_RST = 15'd16384;
	localparam logic [15:0] REPEAT_DELAY_RST   = 16'd400;
	localparam logic [15:0] REPEAT_IVAL_RST    = 16'd150;

	typedef enum logic [2:0] {
		NAV_NONE  = 3'd0,
		NAV_UP    = 3'd1,
		NAV_DOWN  = 3'd2,
		NAV_LEFT  = 3'd3,
		NAV_RIGHT = 3'd4
	} nav_key_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2
	} key_ev_t;

	// quantised direction, two's complement -1/0/+1
	typedef enum logic [1:0] {
		DIR_ZERO = 2'b00,
		DIR_POS  = 2'b01,
		DIR_NEG  = 2'b11
	} dir_t;

	typedef struct packed {
		logic        ui_mode;
		logic [14:0] dead_zone;
		logic [14:0] trig_level;
		logic [15:0] repeat_delay_ms;
		logic [15:0] repeat_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] stick_x;
		logic signed [15:0] stick_y;
		logic [14:0]        paddle_pull;
		logic [14:0]        brake_pull;
		logic               jump_button;
		logic               trick_button;
		logic               pause_button;
		logic               menu_button;
		logic [31:0]        now_ms;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic               paddle_out;
		logic               brake_out;
		logic               charge_out;
		logic               trick_out;
		nav_key_t           nav_key;
		logic               confirm_tap;
		logic               cancel_tap;
		key_ev_t            pause_event;
		key_ev_t            escape_event;
	} result_t;

	// dead zone quantiser, strict compares on both sides
	function automatic dir_t quant(input logic signed [15:0] v, input logic [14:0] dz);
		logic signed [16:0] v_ext;
		logic signed [16:0] dz_pos;
		logic signed [16:0] dz_neg;
		v_ext  = {v[15], v};
		dz_pos = $signed({2'b00, dz});
		dz_neg = -dz_pos;
		if (v_ext > dz_pos) begin
			return DIR_POS;
		end else if (v_ext < dz_neg) begin
			return DIR_NEG;
		end
		return DIR_ZERO;
	endfunction

	// vertical wins over horizontal
	function automatic nav_key_t dir_key(input dir_t dx, input dir_t dy);
		if (dy == DIR_POS) begin
			return NAV_UP;
		end else if (dy == DIR_NEG) begin
			return NAV_DOWN;
		end else if (dx == DIR_NEG) begin
			return NAV_LEFT;
		end else if (dx == DIR_POS) begin
			return NAV_RIGHT;
		end
		return NAV_NONE;
	endfunction

endpackage

>>> sv/tnam_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnam_cfg
// configuration registers and mode-change clear pulse
// ----------------------------------------------------------------------------
module tnam_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	output tnam_pkg::cfg_t      cfg,
	output logic                mode_clear
);

	tnam_pkg::cfg_t cfg_q;

	// only a real mode flip clears the edge and repeat state
	assign mode_clear = cfg_we && (cfg_index == tnam_pkg::REG_UI_MODE)
		&& (cfg_wdata[0] != cfg_q.ui_mode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ui_mode            <= 1'b0;
			cfg_q.dead_zone          <= tnam_pkg::DEAD_ZONE_RST;
			cfg_q.trig_level         <= tnam_pkg::TRIG_THRESHOLD_RST;
			cfg_q.repeat_delay_ms    <= tnam_pkg::REPEAT_DELAY_RST;
			cfg_q.repeat_interval_ms <= tnam_pkg::REPEAT_IVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tnam_pkg::REG_UI_MODE:        cfg_q.ui_mode            <= cfg_wdata[0];
				tnam_pkg::REG_DEAD_ZONE:      cfg_q.dead_zone          <= cfg_wdata[14:0];
				tnam_pkg::REG_TRIG_THRESHOLD: cfg_q.trig_level         <= cfg_wdata[14:0];
				tnam_pkg::REG_REPEAT_DELAY:   cfg_q.repeat_delay_ms    <= cfg_wdata;
				tnam_pkg::REG_REPEAT_IVAL:    cfg_q.repeat_interval_ms <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/tnam_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnam_core
// per-sample mapping logic and its edge, repeat and button state
// ----------------------------------------------------------------------------
module tnam_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tnam_pkg::cfg_t       cfg,
	input  logic                 mode_clear,
	input  logic                 fire,
	input  tnam_pkg::sample_t    smp,
	output tnam_pkg::result_t    res
);

	tnam_pkg::dir_t held_x_q, held_y_q, held_x_d, held_y_d;
	logic [31:0]    deadline_q, deadline_d;
	logic           prev_confirm_q, prev_confirm_d;
	logic           prev_cancel_q, prev_cancel_d;
	logic           prev_pause_q, prev_pause_d;
	logic           prev_menu_q, prev_menu_d;
	logic [3:0]     buttons_q, buttons_d;

	tnam_pkg::dir_t dx, dy;
	logic [31:0]    since_deadline;
	logic           cancel_lvl;

	assign dx             = tnam_pkg::quant(smp.stick_x, cfg.dead_zone);
	assign dy             = tnam_pkg::quant(smp.stick_y, cfg.dead_zone);
	assign since_deadline = smp.now_ms - deadline_q;
	assign cancel_lvl     = smp.pause_button | smp.menu_button;

	always_comb begin
		held_x_d       = held_x_q;
		held_y_d       = held_y_q;
		deadline_d     = deadline_q;
		prev_confirm_d = prev_confirm_q;
		prev_cancel_d  = prev_cancel_q;
		prev_pause_d   = prev_pause_q;
		prev_menu_d    = prev_menu_q;
		buttons_d      = buttons_q;

		res              = '0;
		res.nav_key      = tnam_pkg::NAV_NONE;
		res.pause_event  = tnam_pkg::EV_NONE;
		res.escape_event = tnam_pkg::EV_NONE;

		if (cfg.ui_mode) begin
			if ((dx != held_x_q) || (dy != held_y_q)) begin
				held_x_d    = dx;
				held_y_d    = dy;
				deadline_d  = smp.now_ms + {16'd0, cfg.repeat_delay_ms};
				res.nav_key = tnam_pkg::dir_key(dx, dy);
			end else if (((dx != tnam_pkg::DIR_ZERO) || (dy != tnam_pkg::DIR_ZERO))
					&& !since_deadline[31]) begin
				// wrap-safe: deadline reached when the signed difference is not negative
				deadline_d  = smp.now_ms + {16'd0, cfg.repeat_interval_ms};
				res.nav_key = tnam_pkg::dir_key(dx, dy);
			end
			res.confirm_tap = smp.jump_button && !prev_confirm_q;
			prev_confirm_d  = smp.jump_button;
			res.cancel_tap  = cancel_lvl && !prev_cancel_q;
			prev_cancel_d   = cancel_lvl;
		end else begin
			res.axis_x   = smp.stick_x;
			res.axis_y   = $signed({1'b0, smp.brake_pull}) - $signed({1'b0, smp.paddle_pull});
			buttons_d[0] = smp.paddle_pull > cfg.trig_level;
			buttons_d[1] = smp.brake_pull > cfg.trig_level;
			buttons_d[2] = smp.jump_button;
			buttons_d[3] = smp.trick_button;
			if (smp.pause_button != prev_pause_q) begin
				res.pause_event = smp.pause_button ? tnam_pkg::EV_PRESS : tnam_pkg::EV_RELEASE;
				prev_pause_d    = smp.pause_button;
			end
			if (smp.menu_button != prev_menu_q) begin
				res.escape_event = smp.menu_button ? tnam_pkg::EV_PRESS : tnam_pkg::EV_RELEASE;
				prev_menu_d      = smp.menu_button;
			end
		end

		res.paddle_out = buttons_d[0];
		res.brake_out  = buttons_d[1];
		res.charge_out = buttons_d[2];
		res.trick_out  = buttons_d[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q       <= tnam_pkg::DIR_ZERO;
			held_y_q       <= tnam_pkg::DIR_ZERO;
			deadline_q     <= '0;
			prev_confirm_q <= 1'b0;
			prev_cancel_q  <= 1'b0;
			prev_pause_q   <= 1'b0;
			prev_menu_q    <= 1'b0;
			buttons_q      <= '0;
		end else if (mode_clear) begin
			held_x_q       <= tnam_pkg::DIR_ZERO;
			held_y_q       <= tnam_pkg::DIR_ZERO;
			deadline_q     <= '0;
			prev_confirm_q <= 1'b0;
			prev_cancel_q  <= 1'b0;
			prev_pause_q   <= 1'b0;
			prev_menu_q    <= 1'b0;
		end else if (fire) begin
			held_x_q       <= held_x_d;
			held_y_q       <= held_y_d;
			deadline_q     <= deadline_d;
			prev_confirm_q <= prev_confirm_d;
			prev_cancel_q  <= prev_cancel_d;
			prev_pause_q   <= prev_pause_d;
			prev_menu_q    <= prev_menu_d;
			buttons_q      <= buttons_d;
		end
	end

endmodule

>>> sv/thumbstick_nav_autorepeat_mapper_top.sv
`timescale 1ns / 1ps
// a result passes the input register and then the result register, which holds it until out_ready
// throughput: one sample per cycle while out_ready holds; the state feedback closes within the single mapping stage
// while a result waits, the input register takes one more sample, then in_ready drops
// reset: valids cleared, registers to defaults (game mode), edge, repeat and button state zero
// ----------------------------------------------------------------------------
// thumbstick_nav_autorepeat_mapper_top
// controller sample mapper: menu navigation with auto-repeat, or game axes and key events
// ----------------------------------------------------------------------------
`include "thumbstick_nav_autorepeat_mapper_top_assert.svh"

module thumbstick_nav_autorepeat_mapper_top (
	input  logic               clk,
	input  logic               arst_n,

	// configuration writes
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,

	// sample channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] stick_x,
	input  logic signed [15:0] stick_y,
	input  logic [14:0]        paddle_pull,
	input  logic [14:0]        brake_pull,
	input  logic               jump_button,
	input  logic               trick_button,
	input  logic               pause_button,
	input  logic               menu_button,
	input  logic [31:0]        now_ms,

	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] axis_x,
	output logic signed [15:0] axis_y,
	output logic               paddle_out,
	output logic               brake_out,
	output logic               charge_out,
	output logic               trick_out,
	output logic [2:0]         nav_key,
	output logic               confirm_tap,
	output logic               cancel_tap,
	output logic [1:0]         pause_event,
	output logic [1:0]         escape_event
);

	tnam_pkg::cfg_t    cfg;
	logic              mode_clear;

	logic              valid_s1;
	tnam_pkg::sample_t smp_s1;
	logic              valid_s2;
	tnam_pkg::result_t res_s2;
	tnam_pkg::result_t res;

	logic              adv_s1;   // sample in stage 1 is mapped and moves to the result register
	logic              fire;

	// result register frees up when empty or being taken this cycle
	assign adv_s1   = !valid_s2 || out_ready;
	assign fire     = valid_s1 && adv_s1;
	assign in_ready = !valid_s1 || adv_s1;

	tnam_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cfg        (cfg),
		.mode_clear (mode_clear)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			smp_s1.stick_x      <= stick_x;
			smp_s1.stick_y      <= stick_y;
			smp_s1.paddle_pull  <= paddle_pull;
			smp_s1.brake_pull   <= brake_pull;
			smp_s1.jump_button  <= jump_button;
			smp_s1.trick_button <= trick_button;
			smp_s1.pause_button <= pause_button;
			smp_s1.menu_button  <= menu_button;
			smp_s1.now_ms       <= now_ms;
		end
	end

	// mapping logic plus its state, which commits only when the sample moves on
	tnam_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.mode_clear (mode_clear),
		.fire       (fire),
		.smp        (smp_s1),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign axis_x       = res_s2.axis_x;
	assign axis_y       = res_s2.axis_y;
	assign paddle_out   = res_s2.paddle_out;
	assign brake_out    = res_s2.brake_out;
	assign charge_out   = res_s2.charge_out;
	assign trick_out    = res_s2.trick_out;
	assign nav_key      = res_s2.nav_key;
	assign confirm_tap  = res_s2.confirm_tap;
	assign cancel_tap   = res_s2.cancel_tap;
	assign pause_event  = res_s2.pause_event;
	assign escape_event = res_s2.escape_event;

	// input only backs up when both stages are full and the result is stalled
	`TNAM_ASSERT_NOW(a_ready_stall, !in_ready, valid_s1 && valid_s2 && !out_ready, "in_ready low without a full stalled pipe")
	// a held stage-1 sample is not lost while the output stalls
	`TNAM_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1, valid_s1, "stage-1 sample dropped during stall")
	// navigation outputs and game key events never appear together
	`TNAM_ASSERT_NOW(a_mode_excl, out_valid && (nav_key != tnam_pkg::NAV_NONE || confirm_tap || cancel_tap), pause_event == tnam_pkg::EV_NONE && escape_event == tnam_pkg::EV_NONE && axis_x == 16'sd0 && axis_y == 16'sd0, "navigation and game outputs mixed")
	// only defined navigation codes leave the block
	`TNAM_ASSERT_NOW(a_nav_code, out_valid, nav_key <= tnam_pkg::NAV_RIGHT, "undefined nav_key code")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the thumbstick mapper. Controller polls are queued
// and sent over the valid/ready sample channel with random idle bursts. Each
// accepted poll goes through a local model of the mapper, and each result
// transfer is compared field by field against the oldest predicted result.
// Register settings change between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;

	// indexes past the register list, writes there must be ignored
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// button bit positions used by the poll builder
	localparam logic [3:0] BTN_NONE  = 4'b0000;
	localparam logic [3:0] BTN_JUMP  = 4'b0001;
	localparam logic [3:0] BTN_TRICK = 4'b0010;
	localparam logic [3:0] BTN_PAUSE = 4'b0100;
	localparam logic [3:0] BTN_MENU  = 4'b1000;

	localparam int PHASE_POLLS = 150;
	localparam int NUM_PHASES  = 7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] stick_x = '0;
	logic signed [15:0] stick_y = '0;
	logic [14:0]        paddle_pull = '0;
	logic [14:0]        brake_pull = '0;
	logic               jump_button = 1'b0;
	logic               trick_button = 1'b0;
	logic               pause_button = 1'b0;
	logic               menu_button = 1'b0;
	logic [31:0]        now_ms = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic               paddle_out;
	logic               brake_out;
	logic               charge_out;
	logic               trick_out;
	logic [2:0]         nav_key;
	logic               confirm_tap;
	logic               cancel_tap;
	logic [1:0]         pause_event;
	logic [1:0]         escape_event;

	thumbstick_nav_autorepeat_mapper_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.stick_x      (stick_x),
		.stick_y      (stick_y),
		.paddle_pull  (paddle_pull),
		.brake_pull   (brake_pull),
		.jump_button  (jump_button),
		.trick_button (trick_button),
		.pause_button (pause_button),
		.menu_button  (menu_button),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.axis_x       (axis_x),
		.axis_y       (axis_y),
		.paddle_out   (paddle_out),
		.brake_out    (brake_out),
		.charge_out   (charge_out),
		.trick_out    (trick_out),
		.nav_key      (nav_key),
		.confirm_tap  (confirm_tap),
		.cancel_tap   (cancel_tap),
		.pause_event  (pause_event),
		.escape_event (escape_event)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// mapper model: register copy plus edge, repeat and button memories
	// ------------------------------------------------------------------------
	tnam_pkg::cfg_t regs_now;
	tnam_pkg::dir_t held_x;
	tnam_pkg::dir_t held_y;
	logic [31:0]    repeat_due;
	logic           prev_jump;
	logic           prev_back;
	logic           prev_pause;
	logic           prev_menu;
	logic [3:0]     held_btn;

	tnam_pkg::sample_t polls_to_send[$];   // polls waiting for the sample channel
	tnam_pkg::result_t mapped_due[$];      // predicted results, oldest first

	int  mismatches = 0;
	int  results_seen = 0;
	bit  idle_on = 1'b1;
	int  send_gap = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	tnam_pkg::result_t want;

	function automatic tnam_pkg::dir_t axis_dir(logic signed [15:0] v, logic [14:0] dz);
		int val;
		int lim;
		val = int'(v);
		lim = int'(dz);
		if (val > lim) return tnam_pkg::DIR_POS;
		if (val < -lim) return tnam_pkg::DIR_NEG;
		return tnam_pkg::DIR_ZERO;
	endfunction

	// vertical beats horizontal, up before down, left before right
	function automatic tnam_pkg::nav_key_t heading_key(tnam_pkg::dir_t dx, tnam_pkg::dir_t dy);
		if (dy == tnam_pkg::DIR_POS) return tnam_pkg::NAV_UP;
		if (dy == tnam_pkg::DIR_NEG) return tnam_pkg::NAV_DOWN;
		if (dx == tnam_pkg::DIR_NEG) return tnam_pkg::NAV_LEFT;
		if (dx == tnam_pkg::DIR_POS) return tnam_pkg::NAV_RIGHT;
		return tnam_pkg::NAV_NONE;
	endfunction

	// mode change wipes edges and the repeat timer, buttons survive
	function automatic void clear_edges();
		held_x = tnam_pkg::DIR_ZERO;
		held_y = tnam_pkg::DIR_ZERO;
		repeat_due = '0;
		prev_jump = 1'b0;
		prev_back = 1'b0;
		prev_pause = 1'b0;
		prev_menu = 1'b0;
	endfunction

	function automatic tnam_pkg::result_t map_poll(tnam_pkg::sample_t s);
		tnam_pkg::result_t r;
		tnam_pkg::dir_t dx;
		tnam_pkg::dir_t dy;
		logic [31:0] lag;
		logic back;
		r = '0;
		if (regs_now.ui_mode) begin
			dx = axis_dir(s.stick_x, regs_now.dead_zone);
			dy = axis_dir(s.stick_y, regs_now.dead_zone);
			lag = s.now_ms - repeat_due;
			if (dx != held_x || dy != held_y) begin
				// fresh direction, centre included, rearms the first delay
				held_x = dx;
				held_y = dy;
				repeat_due = s.now_ms + {16'd0, regs_now.repeat_delay_ms};
				r.nav_key = heading_key(dx, dy);
			end else if ((dx != tnam_pkg::DIR_ZERO || dy != tnam_pkg::DIR_ZERO) && !lag[31]) begin
				// deadline reached, compare is wrap safe through the sign bit
				repeat_due = s.now_ms + {16'd0, regs_now.repeat_interval_ms};
				r.nav_key = heading_key(dx, dy);
			end
			r.confirm_tap = s.jump_button && !prev_jump;
			prev_jump = s.jump_button;
			back = s.pause_button | s.menu_button;
			r.cancel_tap = back && !prev_back;
			prev_back = back;
		end else begin
			r.axis_x = s.stick_x;
			r.axis_y = {1'b0, s.brake_pull} - {1'b0, s.paddle_pull};
			held_btn = {s.trick_button, s.jump_button,
				s.brake_pull > regs_now.trig_level,
				s.paddle_pull > regs_now.trig_level};
			if (s.pause_button != prev_pause) begin
				r.pause_event = s.pause_button ? tnam_pkg::EV_PRESS : tnam_pkg::EV_RELEASE;
				prev_pause = s.pause_button;
			end
			if (s.menu_button != prev_menu) begin
				r.escape_event = s.menu_button ? tnam_pkg::EV_PRESS : tnam_pkg::EV_RELEASE;
				prev_menu = s.menu_button;
			end
		end
		// navigation keeps showing the last game-mode buttons
		r.paddle_out = held_btn[0];
		r.brake_out  = held_btn[1];
		r.charge_out = held_btn[2];
		r.trick_out  = held_btn[3];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic tnam_pkg::sample_t pack_poll(int sx, int sy, int pad, int brk,
		logic [3:0] btn, logic [31:0] t);
		tnam_pkg::sample_t s;
		s.stick_x = 16'(sx);
		s.stick_y = 16'(sy);
		s.paddle_pull = 15'(pad);
		s.brake_pull = 15'(brk);
		s.jump_button = btn[0];
		s.trick_button = btn[1];
		s.pause_button = btn[2];
		s.menu_button = btn[3];
		s.now_ms = t;
		return s;
	endfunction

	// stick value that lands in the wanted direction bin, edges of the bin favored
	function automatic logic [15:0] stick_in_bin(int dir, logic [14:0] dz);
		int lo;
		int hi;
		lo = -int'(dz);
		hi = int'(dz);
		if (dir > 0 && dz != 15'h7fff) begin
			lo = int'(dz) + 1;
			hi = 32767;
		end else if (dir < 0) begin
			lo = -32768;
			hi = -int'(dz) - 1;
		end
		case ($urandom_range(7))
			0: return 16'(lo);
			1: return 16'(hi);
			default: return 16'(lo + int'($urandom_range(hi - lo)));
		endcase
	endfunction

	// trigger pull, often right around the threshold
	function automatic logic [14:0] pull_value();
		int v;
		if ($urandom_range(3) == 0) begin
			v = int'(regs_now.trig_level) + int'($urandom_range(2)) - 1;
			if (v < 0) v = 0;
			if (v > 32767) v = 32767;
			return 15'(v);
		end
		return 15'($urandom_range(32767));
	endfunction

	// register write, block must be drained before this is called
	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tnam_pkg::REG_UI_MODE: begin
				if (data[0] != regs_now.ui_mode) begin
					regs_now.ui_mode = data[0];
					clear_edges();
				end
			end
			tnam_pkg::REG_DEAD_ZONE:      regs_now.dead_zone = data[14:0];
			tnam_pkg::REG_TRIG_THRESHOLD: regs_now.trig_level = data[14:0];
			tnam_pkg::REG_REPEAT_DELAY:   regs_now.repeat_delay_ms = data;
			tnam_pkg::REG_REPEAT_IVAL:    regs_now.repeat_interval_ms = data;
			default: ;
		endcase
	endtask

	// every poll sent and every result back, then an idle margin
	task automatic drain();
		while (polls_to_send.size() > 0 || in_valid || mapped_due.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report(string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
		if (got !== exp_val)
			report($sformatf("result %0d %s got %0h want %0h", results_seen, name,
				got, exp_val));
	endtask

	// ------------------------------------------------------------------------
	// sample driver: one transfer in flight, random idle bursts between polls
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				mapped_due.insert(mapped_due.size(), map_poll(polls_to_send[0]));
				void'(polls_to_send.pop_front());
			end
			// hold the offered poll until its transfer, else pick what comes next
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (idle_on && polls_to_send.size() > 0 &&
						$urandom_range(7) == 0) begin
					send_gap = $urandom_range(11);
					in_valid <= 1'b0;
				end else if (polls_to_send.size() > 0) begin
					in_valid <= 1'b1;
					stick_x <= polls_to_send[0].stick_x;
					stick_y <= polls_to_send[0].stick_y;
					paddle_pull <= polls_to_send[0].paddle_pull;
					brake_pull <= polls_to_send[0].brake_pull;
					jump_button <= polls_to_send[0].jump_button;
					trick_button <= polls_to_send[0].trick_button;
					pause_button <= polls_to_send[0].pause_button;
					menu_button <= polls_to_send[0].menu_button;
					now_ms <= polls_to_send[0].now_ms;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor: checks each transfer
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (mapped_due.size() == 0) begin
					report($sformatf("result %0d arrived with nothing pending",
						results_seen));
				end else begin
					want = mapped_due.pop_front();
					check_field("axis_x", 16'(axis_x), 16'(want.axis_x));
					check_field("axis_y", 16'(axis_y), 16'(want.axis_y));
					check_field("paddle_out", 16'(paddle_out), 16'(want.paddle_out));
					check_field("brake_out", 16'(brake_out), 16'(want.brake_out));
					check_field("charge_out", 16'(charge_out), 16'(want.charge_out));
					check_field("trick_out", 16'(trick_out), 16'(want.trick_out));
					check_field("nav_key", 16'(nav_key), 16'(want.nav_key));
					check_field("confirm_tap", 16'(confirm_tap), 16'(want.confirm_tap));
					check_field("cancel_tap", 16'(cancel_tap), 16'(want.cancel_tap));
					check_field("pause_event", 16'(pause_event), 16'(want.pause_event));
					check_field("escape_event", 16'(escape_event),
						16'(want.escape_event));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver throttle: random stalls plus one long back-pressure stretch
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			// long hold while polls keep coming, so the result register fills
			// and in_ready has to drop
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && results_seen >= 300 &&
					polls_to_send.size() > 40) begin
				hold_done = 1'b1;
				hold_left = 199;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(7) == 0) begin
				stall_left = $urandom_range(11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : stim
		int n;
		int k;
		int run_len;
		int hx;
		int hy;
		int span;
		logic [31:0] t;
		logic [3:0]  btn;
		logic [15:0] sx;
		logic [15:0] sy;

		regs_now.ui_mode = 1'b0;
		regs_now.dead_zone = tnam_pkg::DEAD_ZONE_RST;
		regs_now.trig_level = tnam_pkg::TRIG_THRESHOLD_RST;
		regs_now.repeat_delay_ms = tnam_pkg::REPEAT_DELAY_RST;
		regs_now.repeat_interval_ms = tnam_pkg::REPEAT_IVAL_RST;
		clear_edges();
		held_btn = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// game mode at reset settings: axis extremes, pulls at and just past
		// the threshold, pause and escape press and release
		polls_to_send.insert(polls_to_send.size(), pack_poll(-32768, 0, 0, 32767, BTN_NONE, 0));
		polls_to_send.insert(polls_to_send.size(), pack_poll(32767, -32768, 32767, 0,
			BTN_JUMP | BTN_PAUSE, 1));
		polls_to_send.insert(polls_to_send.size(), pack_poll(0, 32767, 16384, 16385,
			BTN_TRICK | BTN_MENU, 2));
		polls_to_send.insert(polls_to_send.size(), pack_poll(1, -1, 16385, 16384,
			BTN_JUMP | BTN_TRICK | BTN_PAUSE | BTN_MENU, 3));
		polls_to_send.insert(polls_to_send.size(), pack_poll(0, 0, 0, 0, BTN_NONE, 4));
		drain();

		// navigation: dead zone edges, each heading, priority on diagonals,
		// first delay then steady repeat, confirm and cancel edges
		write_reg(tnam_pkg::REG_UI_MODE, 16'h0001);
		polls_to_send.insert(polls_to_send.size(), pack_poll(0, 19661, 0, 0, BTN_JUMP, 1000));
		polls_to_send.insert(polls_to_send.size(), pack_poll(0, 19662, 0, 0, BTN_JUMP, 1010));
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(19662, 19662, 0, 0, BTN_PAUSE, 1400));
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(19662, 19662, 0, 0, BTN_PAUSE, 1799));
		polls_to_send.insert(polls_to_send.size(), pack_poll(19662, 19662, 0, 0,
			BTN_PAUSE | BTN_MENU, 1800));
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(-19662, -19661, 0, 0, BTN_MENU, 1900));
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(-19662, -19662, 0, 0, BTN_NONE, 1901));
		polls_to_send.insert(polls_to_send.size(), pack_poll(19662, 0, 0, 0, BTN_MENU, 1902));
		polls_to_send.insert(polls_to_send.size(), pack_poll(0, 0, 0, 0, BTN_NONE, 1903));
		// deadline wraps past zero, earlier timestamps must not repeat
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(0, -19662, 0, 0, BTN_NONE, 32'hffff_ff00));
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(0, -19662, 0, 0, BTN_NONE, 32'hffff_ffff));
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(0, -19662, 0, 0, BTN_NONE, 32'h0000_0090));
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(0, -19662, 0, 0, BTN_NONE, 32'h0000_0010));
		drain();

		// rewriting the same mode keeps the held direction, spare indexes do
		// nothing, zero interval repeats on every poll
		write_reg(tnam_pkg::REG_UI_MODE, 16'h0001);
		write_reg(REG_SPARE_LO, 16'hffff);
		write_reg(REG_SPARE_HI, 16'hffff);
		write_reg(tnam_pkg::REG_REPEAT_IVAL, 16'h0000);
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(0, -19662, 0, 0, BTN_NONE, 32'h0000_0126));
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(0, -19662, 0, 0, BTN_NONE, 32'h0000_0126));
		polls_to_send.insert(polls_to_send.size(),
			pack_poll(0, -19662, 0, 0, BTN_NONE, 32'h0000_0127));
		drain();

		// random phases, extremes first, then random settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					// bit 15 above the 15-bit registers must be dropped
					write_reg(tnam_pkg::REG_UI_MODE, 16'h0001);
					write_reg(tnam_pkg::REG_DEAD_ZONE, 16'h8000);
					write_reg(tnam_pkg::REG_TRIG_THRESHOLD, 16'h8000);
					write_reg(tnam_pkg::REG_REPEAT_DELAY, 16'h0000);
					write_reg(tnam_pkg::REG_REPEAT_IVAL, 16'h0000);
				end
				1: begin
					write_reg(tnam_pkg::REG_UI_MODE, 16'hfffe);
					write_reg(tnam_pkg::REG_DEAD_ZONE, 16'hffff);
					write_reg(tnam_pkg::REG_TRIG_THRESHOLD, 16'h7fff);
					write_reg(tnam_pkg::REG_REPEAT_DELAY, 16'hffff);
					write_reg(tnam_pkg::REG_REPEAT_IVAL, 16'hffff);
				end
				2: begin
					write_reg(tnam_pkg::REG_UI_MODE, 16'h0001);
					write_reg(tnam_pkg::REG_DEAD_ZONE, 16'h7fff);
					write_reg(tnam_pkg::REG_TRIG_THRESHOLD, 16'($urandom_range(32767)));
					write_reg(tnam_pkg::REG_REPEAT_DELAY, 16'hffff);
					write_reg(tnam_pkg::REG_REPEAT_IVAL, 16'h0001);
				end
				default: begin
					write_reg(tnam_pkg::REG_UI_MODE, (p == 5) ? 16'h0000 : 16'h0001);
					write_reg(tnam_pkg::REG_DEAD_ZONE, 16'($urandom_range(32767)));
					write_reg(tnam_pkg::REG_TRIG_THRESHOLD, 16'($urandom_range(32767)));
					write_reg(tnam_pkg::REG_REPEAT_DELAY, 16'($urandom_range(2000)));
					write_reg(tnam_pkg::REG_REPEAT_IVAL, 16'($urandom_range(500, 1)));
					write_reg(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
						16'($urandom));
				end
			endcase
			// last phase runs both channels flat out
			if (p == NUM_PHASES - 1)
				idle_on = 1'b0;

			// held runs of one heading with advancing time so repeats fire,
			// some fully random sticks and time jumps as noise
			span = (int'(regs_now.repeat_delay_ms) + int'(regs_now.repeat_interval_ms)) / 3 + 4;
			t = $urandom;
			btn = 4'($urandom);
			n = 0;
			while (n < PHASE_POLLS) begin
				run_len = $urandom_range(20, 1);
				hx = int'($urandom_range(2)) - 1;
				hy = int'($urandom_range(2)) - 1;
				for (k = 0; k < run_len && n < PHASE_POLLS; k++) begin
					if ($urandom_range(9) == 0) begin
						sx = 16'($urandom);
						sy = 16'($urandom);
					end else begin
						sx = stick_in_bin(hx, regs_now.dead_zone);
						sy = stick_in_bin(hy, regs_now.dead_zone);
					end
					t = t + 32'($urandom_range(span));
					if ($urandom_range(49) == 0)
						t = $urandom;
					btn = btn ^ 4'($urandom & $urandom);
					polls_to_send.insert(polls_to_send.size(),
						pack_poll(int'(sx), int'(sy), int'(pull_value()),
						int'(pull_value()), btn, t));
					n++;
				end
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/tnam_pkg.sv
sv/tnam_cfg.sv
sv/tnam_core.sv
sv/thumbstick_nav_autorepeat_mapper_top.sv
dv/tb_top.sv
